/* design/sbm_pkg.sv */
// Shared types, constants and the log2 fraction table for the spectrum bar meter.
// No dependencies; imported by every module of the block.
package sbm_pkg;

    localparam int BarCount  = 32;
    localparam int FftPoints = 512;
    localparam int FftLog2   = $clog2(FftPoints);
    localparam int BandW     = 5;
    localparam int QueueDepth = 4;

    // Configuration register indexes.
    localparam logic [2:0] REG_DISPLAY_HEIGHT = 3'd0;
    localparam logic [2:0] REG_FLOOR_DB       = 3'd1;
    localparam logic [2:0] REG_CEILING_DB     = 3'd2;
    localparam logic [2:0] REG_RISE_OLD       = 3'd3;
    localparam logic [2:0] REG_RISE_NEW       = 3'd4;
    localparam logic [2:0] REG_FALL_OLD       = 3'd5;
    localparam logic [2:0] REG_FALL_NEW       = 3'd6;
    localparam logic [2:0] REG_CAP_STEP       = 3'd7;

    // One finished band handed from the accumulator to the band processor.
    typedef struct packed {
        logic [BandW-1:0] band;
        logic [63:0]      power;
        logic [15:0]      pairs;
    } band_job_t;

    typedef struct packed {
        logic [7:0]         display_height;
        logic signed [11:0] floor_db;
        logic signed [11:0] ceiling_db;
        logic [7:0]         rise_old;
        logic [7:0]         rise_new;
        logic [7:0]         fall_old;
        logic [7:0]         fall_new;
        logic [15:0]        cap_step;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MSB,
        ST_LOG,
        ST_DB,
        ST_MAP,
        ST_DIV1,
        ST_SMOOTH,
        ST_DIV2,
        ST_UPDATE,
        ST_OUT
    } back_state_t;

    // round(256*log2(1+m/32))
    function automatic logic [7:0] log_frac(input logic [4:0] m);
        logic [7:0] t [32];
        t = '{8'd0, 8'd11, 8'd22, 8'd33, 8'd44, 8'd54, 8'd63, 8'd73,
              8'd82, 8'd92, 8'd100, 8'd109, 8'd118, 8'd126, 8'd134, 8'd142,
              8'd150, 8'd157, 8'd165, 8'd172, 8'd179, 8'd186, 8'd193, 8'd200,
              8'd207, 8'd213, 8'd220, 8'd226, 8'd232, 8'd238, 8'd244, 8'd250};
        return t[m];
    endfunction

endpackage

/* design/spectrum_band_meter_with_peak_caps.sv */
// Top level of the spectrum bar meter: config registers, front end, queue, back end.
// Depends on sbm_pkg, sbm_front, sbm_queue and sbm_back.
//
//  channel | signals                                    | transfer when
//  input   | valid, stall, band_number, bin parts, done | valid && !stall
//  output  | out_valid, out_stall, bar_band/rows, cap   | out_valid && !out_stall
//  config  | cfg_valid, cfg_ready, cfg_index, cfg_data  | cfg_valid && cfg_ready
//
// Bin pairs enter one per cycle while not stalled, through a two-stage multiply
// and accumulate. Each band end passes through the band processor as a leading-one
// scan and up to two serial divisions.
// Reset clears per-band stores through valid bits; input stalls when the job
// queue nears full, and the output register holds under stall.
module spectrum_band_meter_with_peak_caps (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      valid,
    output logic                      stall,
    input  logic [sbm_pkg::BandW-1:0] band_number,
    input  logic signed [23:0]        low_bin_real,
    input  logic signed [23:0]        low_bin_imag,
    input  logic signed [23:0]        high_bin_real,
    input  logic signed [23:0]        high_bin_imag,
    input  logic                      band_done,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [sbm_pkg::BandW-1:0] bar_band,
    output logic [7:0]                bar_rows,
    output logic [7:0]                cap_row,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [2:0]                cfg_index,
    input  logic [15:0]               cfg_data
);
    import sbm_pkg::*;

    cfg_t      cfg_reg;
    logic      fj_valid, q_full, q_valid, q_take;
    band_job_t fj, qj;

    assign cfg_ready = 1'b1;

    // Configuration register file.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.display_height <= 8'd20;
            cfg_reg.floor_db       <= -12'sd960;
            cfg_reg.ceiling_db     <= 12'sd0;
            cfg_reg.rise_old       <= 8'd1;
            cfg_reg.rise_new       <= 8'd1;
            cfg_reg.fall_old       <= 8'd3;
            cfg_reg.fall_new       <= 8'd1;
            cfg_reg.cap_step       <= 16'd256;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_DISPLAY_HEIGHT: cfg_reg.display_height <= cfg_data[7:0];
                REG_FLOOR_DB:       cfg_reg.floor_db       <= cfg_data[11:0];
                REG_CEILING_DB:     cfg_reg.ceiling_db     <= cfg_data[11:0];
                REG_RISE_OLD:       cfg_reg.rise_old       <= cfg_data[7:0];
                REG_RISE_NEW:       cfg_reg.rise_new       <= cfg_data[7:0];
                REG_FALL_OLD:       cfg_reg.fall_old       <= cfg_data[7:0];
                REG_FALL_NEW:       cfg_reg.fall_new       <= cfg_data[7:0];
                REG_CAP_STEP:       cfg_reg.cap_step       <= cfg_data;
                default: ;
            endcase
        end
    end

    sbm_front u_front (
        .clk, .rst_n, .valid, .stall, .band_number,
        .low_bin_real, .low_bin_imag, .high_bin_real, .high_bin_imag, .band_done,
        .job_valid(fj_valid), .job(fj), .job_full(q_full)
    );

    sbm_queue u_queue (
        .clk, .rst_n, .wr_valid(fj_valid), .wr_data(fj), .almost_full(q_full),
        .rd_valid(q_valid), .rd_take(q_take), .rd_data(qj)
    );

    sbm_back u_back (
        .clk, .rst_n, .cfg(cfg_reg), .job_valid(q_valid), .job(qj), .job_take(q_take),
        .out_valid, .out_stall, .bar_band, .bar_rows, .cap_row
    );

endmodule

/* design/sbm_front.sv */
// Front end: squares bin pairs, accumulates band power and pair count.
// Depends on sbm_pkg. Emits one band job per band_done of a valid band.
module sbm_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      valid,
    output logic                      stall,
    input  logic [sbm_pkg::BandW-1:0] band_number,
    input  logic signed [23:0]        low_bin_real,
    input  logic signed [23:0]        low_bin_imag,
    input  logic signed [23:0]        high_bin_real,
    input  logic signed [23:0]        high_bin_imag,
    input  logic                      band_done,
    output logic                      job_valid,
    output sbm_pkg::band_job_t        job,
    input  logic                      job_full
);
    import sbm_pkg::*;

    // Stage 1 registers: squared parts.
    logic               s1_valid_reg;
    logic [47:0]        lrr_reg, lii_reg, hrr_reg, hii_reg;
    logic               s1_done_reg;
    logic [BandW-1:0]   s1_band_reg;
    // Stage 2 registers: pair power.
    logic               s2_valid_reg;
    logic [48:0]        add_reg;
    logic               s2_done_reg;
    logic [BandW-1:0]   s2_band_reg;
    // Accumulator.
    logic [63:0]        sum_reg;
    logic [15:0]        cnt_reg;

    logic               accept;
    logic [47:0]        lp, hp;
    logic [64:0]        sum_wide;
    logic [63:0]        sum_new;
    logic [15:0]        cnt_new;

    // Hold input off while the queue may not absorb what is in flight.
    assign stall  = job_full;
    assign accept = valid && !stall;

    // Square each part; products of equal signed values are non-negative.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        lrr_reg     <= 48'(low_bin_real * low_bin_real);
        lii_reg     <= 48'(low_bin_imag * low_bin_imag);
        hrr_reg     <= 48'(high_bin_real * high_bin_real);
        hii_reg     <= 48'(high_bin_imag * high_bin_imag);
        s1_done_reg <= band_done;
        s1_band_reg <= band_number;
        add_reg     <= {1'b0, lp} + {1'b0, hp};
        s2_done_reg <= s1_done_reg;
        s2_band_reg <= s1_band_reg;
    end

    // Absolute difference of the squares for each bin.
    assign lp = (lrr_reg >= lii_reg) ? lrr_reg - lii_reg : lii_reg - lrr_reg;
    assign hp = (hrr_reg >= hii_reg) ? hrr_reg - hii_reg : hii_reg - hrr_reg;

    // Saturating accumulation.
    assign sum_wide = {1'b0, sum_reg} + {16'd0, add_reg};
    assign sum_new  = sum_wide[64] ? '1 : sum_wide[63:0];
    assign cnt_new  = (cnt_reg == 16'hFFFF) ? cnt_reg : cnt_reg + 16'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            cnt_reg <= '0;
        end
        else if (s2_valid_reg)
        begin
            if (s2_done_reg)
            begin
                sum_reg <= '0;
                cnt_reg <= '0;
            end
            else
            begin
                sum_reg <= sum_new;
                cnt_reg <= cnt_new;
            end
        end
    end

    // Job handoff at band end; bands beyond the bar count give no job.
    assign job_valid = s2_valid_reg && s2_done_reg
                       && (32'(s2_band_reg) < 32'(BarCount));
    assign job.band  = s2_band_reg;
    assign job.power = sum_new;
    assign job.pairs = cnt_new;

endmodule

/* design/sbm_queue.sv */
// Short job queue between front end and band processor.
// Depends on sbm_pkg. Reports full early enough for two jobs already in flight.
module sbm_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_valid,
    input  sbm_pkg::band_job_t wr_data,
    output logic               almost_full,
    output logic               rd_valid,
    input  logic               rd_take,
    output sbm_pkg::band_job_t rd_data
);
    import sbm_pkg::*;

    localparam int PtrW = $clog2(QueueDepth);

    band_job_t         mem [QueueDepth];
    logic [PtrW-1:0]   wp_reg, rp_reg;
    logic [PtrW:0]     cnt_reg;
    logic              do_rd;

    assign rd_valid    = cnt_reg != '0;
    assign do_rd       = rd_take && rd_valid;
    assign rd_data     = mem[rp_reg];
    // Two pipeline stages can still deliver after input stops.
    assign almost_full = 32'(cnt_reg) >= QueueDepth - 2;

    // Storage write.
    always_ff @(posedge clk)
    begin
        if (wr_valid)
        begin
            mem[wp_reg] <= wr_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_valid) wp_reg <= wp_reg + 1'b1;
            if (do_rd) rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (PtrW+1)'(wr_valid) - (PtrW+1)'(do_rd);
        end
    end

endmodule

/* design/sbm_back.sv */
// Band processor: log2, dB mapping, smoothing and peak cap per band.
// Depends on sbm_pkg. Uses one shared serial divider for both divisions.
module sbm_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  sbm_pkg::cfg_t             cfg,
    input  logic                      job_valid,
    input  sbm_pkg::band_job_t        job,
    output logic                      job_take,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [sbm_pkg::BandW-1:0] bar_band,
    output logic [7:0]                bar_rows,
    output logic [7:0]                cap_row
);
    import sbm_pkg::*;

    back_state_t        state_reg, state_next;
    band_job_t          job_reg;
    logic [5:0]         ep_reg, ed_reg;
    logic [63:0]        scan_p_reg;
    logic [31:0]        scan_d_reg;
    logic signed [15:0] l_diff_reg;
    logic signed [23:0] db_reg;
    logic               empty_reg;
    logic signed [15:0] target_reg, prev_reg, h_reg;
    logic [15:0]        cap_old_reg;
    // Serial divider: 40-bit magnitude numerator, 17-bit divisor.
    logic [39:0]        q_reg;
    logic [16:0]        r_reg;
    logic [16:0]        dv_reg;
    logic               neg_reg;
    logic [5:0]         it_reg;
    logic               rise_reg;
    logic [BandW-1:0]   ob_reg;
    logic [7:0]         orow_reg, ocap_reg;
    logic               ov_reg;

    logic signed [15:0] hgt_mem [BarCount];
    logic [15:0]        cap_mem [BarCount];
    logic [BarCount-1:0] written_reg;

    logic [31:0]        den;
    logic [17:0]        rem_try;
    logic signed [40:0] quot_s;
    logic signed [15:0] quot_sat;
    logic [4:0]         mp, md;
    logic signed [16:0] lp, ld;
    logic signed [12:0] span;
    logic signed [39:0] num_map;
    logic [8:0]         wsum;
    logic signed [39:0] num_sm;
    logic signed [15:0] clipped;
    logic [15:0]        cap_dec, cap_floor, cap_new;
    logic               div_busy;

    assign den = {15'd0, job_reg.pairs, 1'b0} << FftLog2;

    // Mantissa bits just below the leading one.
    assign mp = (ep_reg >= 6'd5) ? 5'(job_reg.power >> (ep_reg - 6'd5))
                                 : 5'(job_reg.power << (6'd5 - ep_reg));
    assign md = (ed_reg >= 6'd5) ? 5'(den >> (ed_reg - 6'd5))
                                 : 5'(den << (6'd5 - ed_reg));
    assign lp = $signed({1'b0, ep_reg, 2'b00, 8'd0}) >>> 2;
    assign ld = $signed({1'b0, ed_reg, 2'b00, 8'd0}) >>> 2;

    assign span    = 13'(cfg.ceiling_db) - 13'(cfg.floor_db);
    assign num_map = 40'((db_reg - 24'(cfg.floor_db)) * $signed({1'b0, cfg.display_height}));
    assign wsum    = rise_reg ? 9'(cfg.rise_old) + 9'(cfg.rise_new)
                              : 9'(cfg.fall_old) + 9'(cfg.fall_new);
    assign num_sm  = rise_reg
        ? 40'(prev_reg * $signed({1'b0, cfg.rise_old}))
          + 40'(target_reg * $signed({1'b0, cfg.rise_new}))
        : 40'(prev_reg * $signed({1'b0, cfg.fall_old}))
          + 40'(target_reg * $signed({1'b0, cfg.fall_new}));

    // Restoring divider step and signed, saturated quotient.
    assign rem_try  = {r_reg, q_reg[39]} - {1'b0, dv_reg};
    assign quot_s   = neg_reg ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});
    assign quot_sat = (quot_s > 41'sd32767) ? 16'sd32767
                    : (quot_s < -41'sd32768) ? -16'sd32768 : 16'(quot_s);
    assign div_busy = it_reg != '0;

    assign clipped = (h_reg < 0) ? 16'sd0
                   : (h_reg > $signed({8'd0, cfg.display_height}))
                     ? $signed({8'd0, cfg.display_height}) : h_reg;
    assign cap_dec   = (cap_old_reg > cfg.cap_step) ? cap_old_reg - cfg.cap_step : 16'd0;
    assign cap_floor = {clipped[7:0], 8'd0};
    assign cap_new   = (cap_dec < cap_floor) ? cap_floor : cap_dec;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (job_valid) state_next = ST_MSB;
            ST_MSB:    if (scan_p_reg[63] && scan_d_reg[31]) state_next = ST_LOG;
            ST_LOG:    state_next = ST_DB;
            ST_DB:     state_next = ST_MAP;
            ST_MAP:    state_next = empty_reg ? ST_SMOOTH : ST_DIV1;
            ST_DIV1:   if (!div_busy) state_next = ST_SMOOTH;
            ST_SMOOTH: state_next = (wsum == '0) ? ST_UPDATE : ST_DIV2;
            ST_DIV2:   if (!div_busy) state_next = ST_UPDATE;
            ST_UPDATE: state_next = ST_OUT;
            ST_OUT:    if (!ov_reg || !out_stall) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Outputs of the state machine.
    always_comb
    begin
        job_take = 1'b0;
        unique case (state_reg)
            ST_IDLE: job_take = job_valid;
            default: job_take = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            written_reg <= '0;
            ov_reg      <= 1'b0;
            it_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (ov_reg && !out_stall) ov_reg <= 1'b0;
            if (div_busy) it_reg <= it_reg - 6'd1;
            unique case (state_reg)
                ST_MAP:    if (!empty_reg) it_reg <= 6'd40;
                ST_SMOOTH: if (wsum != '0) it_reg <= 6'd40;
                ST_UPDATE: written_reg[job_reg.band] <= 1'b1;
                ST_OUT:    if (!ov_reg || !out_stall) ov_reg <= 1'b1;
                default:   ;
            endcase
        end
    end

    // Datapath.
    always_ff @(posedge clk)
    begin
        if (div_busy)
        begin
            if (!rem_try[17])
            begin
                r_reg <= rem_try[16:0];
                q_reg <= {q_reg[38:0], 1'b1};
            end
            else
            begin
                r_reg <= {r_reg[15:0], q_reg[39]};
                q_reg <= {q_reg[38:0], 1'b0};
            end
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                job_reg    <= job;
                ep_reg     <= 6'd63;
                ed_reg     <= 6'd31;
                scan_p_reg <= job.power;
                scan_d_reg <= {15'd0, job.pairs, 1'b0} << FftLog2;
                empty_reg  <= (job.pairs == '0) || (job.power == '0);
            end
            ST_MSB:
            begin
                // One bit of the leading-one search per cycle for both words.
                if (!scan_p_reg[63] && ep_reg != '0)
                begin
                    scan_p_reg <= scan_p_reg << 1;
                    ep_reg     <= ep_reg - 6'd1;
                end
                else
                begin
                    scan_p_reg[63] <= 1'b1;
                end
                if (!scan_d_reg[31] && ed_reg != '0)
                begin
                    scan_d_reg <= scan_d_reg << 1;
                    ed_reg     <= ed_reg - 6'd1;
                end
                else
                begin
                    scan_d_reg[31] <= 1'b1;
                end
            end
            ST_LOG:
            begin
                l_diff_reg <= 16'(lp + 17'(log_frac(mp)) - ld - 17'(log_frac(md)) - 17'sd4096);
                prev_reg   <= written_reg[job_reg.band] ? hgt_mem[job_reg.band] : 16'sd0;
                cap_old_reg <= written_reg[job_reg.band] ? cap_mem[job_reg.band] : 16'd0;
            end
            ST_DB:
                db_reg <= 24'(($signed({{8{l_diff_reg[15]}}, l_diff_reg}) * 24'sd771) >>> 12);
            ST_MAP:
            begin
                neg_reg <= num_map[39];
                q_reg   <= num_map[39] ? 40'(-num_map) : num_map;
                r_reg   <= '0;
                dv_reg  <= (span <= 0) ? 17'd1 : 17'(span);
                if (empty_reg) target_reg <= -16'sd32768;
            end
            ST_DIV1:
                if (!div_busy) target_reg <= quot_sat;
            ST_SMOOTH:
            begin
                neg_reg  <= num_sm[39];
                q_reg    <= num_sm[39] ? 40'(-num_sm) : num_sm;
                r_reg    <= '0;
                dv_reg   <= {8'd0, wsum};
                if (wsum == '0) h_reg <= target_reg;
            end
            ST_DIV2:
                if (!div_busy) h_reg <= quot_sat;
            ST_UPDATE:
            begin
                hgt_mem[job_reg.band] <= h_reg;
                cap_mem[job_reg.band] <= cap_new;
            end
            ST_OUT:
            begin
                // Load the output register only once the previous transfer is gone.
                if (!ov_reg || !out_stall)
                begin
                    ob_reg   <= job_reg.band;
                    orow_reg <= clipped[7:0];
                    ocap_reg <= cap_new[15:8];
                end
            end
            default: ;
        endcase
        // Select the weight pair as soon as the target is known.
        if (state_reg == ST_DIV1 && !div_busy)
        begin
            rise_reg <= quot_sat > prev_reg;
        end
        else if (state_reg == ST_MAP && empty_reg)
        begin
            rise_reg <= 1'b0;
        end
    end

    assign out_valid = ov_reg;
    assign bar_band  = ob_reg;
    assign bar_rows  = orow_reg;
    assign cap_row   = ocap_reg;

endmodule
